@@ design/gbsw_pkg.sv @@
// Shared types, codes and helper functions of the GIF block structure walker.
package gbsw_pkg;

  localparam int unsigned LEN_W     = 40;
  localparam int unsigned MIN_W     = 16;
  localparam int unsigned CFG_W     = 40;
  localparam int unsigned ADD_W     = 11;
  localparam int unsigned HDR_BYTES = 6;

  localparam logic [7:0] BLK_EXTENSION = 8'h21;
  localparam logic [7:0] BLK_IMAGE     = 8'h2c;
  localparam logic [7:0] BLK_TRAILER   = 8'h3b;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] SIG_VER_NINE  = 8'h39;

  localparam logic [ADD_W-1:0] SCREEN_END   = 11'd13;
  localparam logic [ADD_W-1:0] EXT_SKIP     = 11'd2;
  localparam logic [ADD_W-1:0] IMAGE_SKIP   = 11'd9;
  localparam logic [ADD_W-1:0] DESC_SKIP    = 11'd2;
  localparam logic [ADD_W-1:0] SUB_SKIP     = 11'd1;
  localparam int unsigned      SCREEN_FLAGS = 10;

  localparam logic [LEN_W-1:0] MAX_SIZE_RESET = 40'hFF_FFFF_FFFF;
  localparam logic [MIN_W-1:0] MIN_SIZE_RESET = 16'd42;

  typedef enum logic {
    REG_MAX_SIZE = 1'b0,
    REG_MIN_SIZE = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_VALID  = 3'd1,
    ST_FORMAT = 3'd2,
    ST_LIMIT  = 3'd3,
    ST_TRUNC  = 3'd4,
    ST_SHORT  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BLOCK  = 2'd1,
    PH_SUB    = 2'd2,
    PH_DESC   = 2'd3
  } phase_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] file_length;
  } result_t;

  // Expected signature byte, "GIF87a"; the version digit may also be '9'.
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h47;
      3'd1:    b = 8'h49;
      3'd2:    b = 8'h46;
      3'd3:    b = 8'h38;
      3'd4:    b = 8'h37;
      3'd5:    b = 8'h61;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Color table size in bytes for a flags byte, zero when no table follows.
  function automatic logic [9:0] table_bytes(input logic [7:0] flags);
    logic [9:0] n;
    if (!flags[7]) begin
      n = 10'd0;
    end else begin
      n = 10'd3 << (4'(flags[2:0]) + 4'd1);
    end
    return n;
  endfunction

endpackage

@@ design/gbsw_byte_if.sv @@
// Input byte channel: one transaction carries one byte of the candidate file.
interface gbsw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output first_byte, output end_of_data,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input end_of_data,
                  output ready);
endinterface

@@ design/gbsw_result_if.sv @@
// Result channel: one transaction carries the walk status for one input byte.
interface gbsw_result_if import gbsw_pkg::*; ;
  logic             valid;
  logic             ready;
  status_t          status;
  logic [LEN_W-1:0] file_length;

  modport source (output valid, output status, output file_length, input ready);
  modport sink   (input valid, input status, input file_length, output ready);
endinterface

@@ design/gbsw_step.sv @@
// Per-byte walk logic: next walk state and the result for one accepted byte.
module gbsw_step import gbsw_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 40
) (
  input  logic [7:0]             data_byte,
  input  logic                   first_byte,
  input  logic                   end_of_data,
  input  logic [OFFSET_BITS-1:0] byte_position,
  input  logic [OFFSET_BITS-1:0] next_mark,
  input  phase_t                 walk_phase,
  input  logic [7:0]             previous_byte,
  input  logic                   first_block_seen,
  input  logic                   walk_finished,
  input  logic [LEN_W-1:0]       max_file_size,
  input  logic [MIN_W-1:0]       min_file_size,
  output logic [OFFSET_BITS-1:0] byte_position_next,
  output logic [OFFSET_BITS-1:0] next_mark_next,
  output phase_t                 walk_phase_next,
  output logic [7:0]             previous_byte_next,
  output logic                   first_block_seen_next,
  output logic                   walk_finished_next,
  output result_t                result
);

  localparam int unsigned CMP_W = (OFFSET_BITS + 1 > LEN_W) ? OFFSET_BITS + 1 : LEN_W;

  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS-1:0] mark;
  phase_t                 phase;
  logic [7:0]             prev;
  logic                   seen;
  logic                   fin;

  logic [OFFSET_BITS-1:0] mark_base;
  logic [ADD_W-1:0]       mark_add;
  logic                   mark_set;
  logic [OFFSET_BITS:0]   new_mark;
  logic                   at_limit;
  logic [OFFSET_BITS:0]   len;
  logic [CMP_W-1:0]       len_c;
  logic                   sig_ok;
  status_t                status;
  logic                   done;

  // A first byte restarts the walk before the byte itself is looked at.
  always_comb begin
    if (first_byte) begin
      pos   = '0;
      mark  = '0;
      phase = PH_HEADER;
      prev  = BYTE_ZERO;
      seen  = 1'b0;
      fin   = 1'b0;
    end else begin
      pos   = byte_position;
      mark  = next_mark;
      phase = walk_phase;
      prev  = previous_byte;
      seen  = first_block_seen;
      fin   = walk_finished;
    end
  end

  assign new_mark = {1'b0, mark_base} + (OFFSET_BITS + 1)'(mark_add);
  assign at_limit = (CMP_W'(new_mark) >= CMP_W'(max_file_size)) || new_mark[OFFSET_BITS];
  assign len      = {1'b0, pos} + (OFFSET_BITS + 1)'(1);
  assign len_c    = CMP_W'(len);
  assign sig_ok   = (data_byte == sig_byte(pos[2:0])) ||
                    (pos[2:0] == 3'd4 && data_byte == SIG_VER_NINE);

  always_comb begin
    mark_base             = pos;
    mark_add              = '0;
    mark_set              = 1'b0;
    status                = ST_RUN;
    done                  = 1'b0;
    walk_phase_next       = phase;
    first_block_seen_next = seen;
    result.file_length    = '0;

    if (!fin) begin
      unique case (phase)
        PH_HEADER: begin
          if (pos < OFFSET_BITS'(HDR_BYTES)) begin
            if (!sig_ok) begin
              status = ST_FORMAT;
              done   = 1'b1;
            end
          end else if (pos == OFFSET_BITS'(SCREEN_FLAGS)) begin
            walk_phase_next = PH_BLOCK;
            mark_base       = '0;
            mark_add        = SCREEN_END + ADD_W'(table_bytes(data_byte));
            mark_set        = 1'b1;
          end
        end
        PH_BLOCK: begin
          if (pos == mark) begin
            if (data_byte == BLK_EXTENSION) begin
              first_block_seen_next = 1'b1;
              walk_phase_next       = PH_SUB;
              mark_add              = EXT_SKIP;
              mark_set              = 1'b1;
            end else if (data_byte == BLK_IMAGE) begin
              first_block_seen_next = 1'b1;
              walk_phase_next       = PH_DESC;
              mark_add              = IMAGE_SKIP;
              mark_set              = 1'b1;
            end else if (data_byte == BLK_TRAILER && seen) begin
              done = 1'b1;
              if (prev != BYTE_ZERO) begin
                status = ST_FORMAT;
              end else if (len_c < CMP_W'(min_file_size)) begin
                status = ST_SHORT;
              end else begin
                status             = ST_VALID;
                result.file_length = len_c[LEN_W-1:0];
              end
            end else begin
              status = ST_FORMAT;
              done   = 1'b1;
            end
          end
        end
        PH_DESC: begin
          if (pos == mark) begin
            walk_phase_next = PH_SUB;
            mark_add        = DESC_SKIP + ADD_W'(table_bytes(data_byte));
            mark_set        = 1'b1;
          end
        end
        PH_SUB: begin
          if (pos == mark) begin
            mark_add = SUB_SKIP + ADD_W'(data_byte);
            mark_set = 1'b1;
            // A zero-length sub-block closes the chain, unless the limit hit first.
            if (data_byte == BYTE_ZERO && !at_limit) begin
              walk_phase_next = PH_BLOCK;
            end
          end
        end
        default: begin
          status = ST_FORMAT;
          done   = 1'b1;
        end
      endcase

      if (mark_set && at_limit) begin
        status = ST_LIMIT;
        done   = 1'b1;
      end
      if (!done && end_of_data) begin
        status = ST_TRUNC;
        done   = 1'b1;
      end
    end
    result.status = status;
  end

  always_comb begin
    if (fin) begin
      byte_position_next = pos;
      next_mark_next     = mark;
      previous_byte_next = prev;
      walk_finished_next = fin;
    end else begin
      byte_position_next = len[OFFSET_BITS-1:0];
      next_mark_next     = mark_set ? new_mark[OFFSET_BITS-1:0] : mark;
      previous_byte_next = data_byte;
      walk_finished_next = done;
    end
  end

endmodule

@@ design/gbsw_out_stage.sv @@
// Result register: holds one result until the downstream side takes it.
module gbsw_out_stage import gbsw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  result_t              d,
  output logic                 can_load,
  gbsw_result_if.source        result_out
);

  logic    valid;
  result_t held;

  // A new result may enter when the register is empty or is emptied this cycle.
  assign can_load = !valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
    if (load && can_load) begin
      held <= d;
    end
  end

  assign result_out.valid       = valid;
  assign result_out.status      = held.status;
  assign result_out.file_length = held.file_length;

endmodule

@@ design/gbsw_walker_regs.sv @@
// Walk state registers and configuration registers of the walker.
module gbsw_walker_regs import gbsw_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic [OFFSET_BITS-1:0] byte_position_next,
  input  logic [OFFSET_BITS-1:0] next_mark_next,
  input  phase_t                 walk_phase_next,
  input  logic [7:0]             previous_byte_next,
  input  logic                   first_block_seen_next,
  input  logic                   walk_finished_next,
  output logic [OFFSET_BITS-1:0] byte_position,
  output logic [OFFSET_BITS-1:0] next_mark,
  output phase_t                 walk_phase,
  output logic [7:0]             previous_byte,
  output logic                   first_block_seen,
  output logic                   walk_finished,
  output logic [LEN_W-1:0]       max_file_size,
  output logic [MIN_W-1:0]       min_file_size
);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      next_mark        <= '0;
      walk_phase       <= PH_HEADER;
      previous_byte    <= BYTE_ZERO;
      first_block_seen <= 1'b0;
      walk_finished    <= 1'b0;
    end else if (advance) begin
      byte_position    <= byte_position_next;
      next_mark        <= next_mark_next;
      walk_phase       <= walk_phase_next;
      previous_byte    <= previous_byte_next;
      first_block_seen <= first_block_seen_next;
      walk_finished    <= walk_finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_file_size <= MAX_SIZE_RESET;
      min_file_size <= MIN_SIZE_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_MAX_SIZE: max_file_size <= cfg_data[LEN_W-1:0];
        REG_MIN_SIZE: min_file_size <= cfg_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/gif_block_structure_walker.sv @@
// Top level of the GIF block structure walker, which finds the length of a GIF file.
//
//   channel      direction  payload                                 accepted when
//   byte_in      in         data_byte, first_byte, end_of_data      valid && ready
//   result_out   out        status, file_length                     valid && ready
//   cfg_*        in         cfg_index, cfg_data                     cfg_write
//
// One result per byte. A byte is accepted in any cycle in which the result
// register is empty or is being read, so the walker sustains one byte per clock while the result side is ready.
// The result of a byte appears in the result register in the cycle after acceptance.
// The limit on the clock is the offset adder and the size-limit compare.
// rst is synchronous; it restores the walk state and both size registers.
module gif_block_structure_walker import gbsw_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 40
) (
  input  logic              clk,
  input  logic              rst,
  gbsw_byte_if.sink         byte_in,
  gbsw_result_if.source     result_out,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] next_mark;
  phase_t                 walk_phase;
  logic [7:0]             previous_byte;
  logic                   first_block_seen;
  logic                   walk_finished;
  logic [OFFSET_BITS-1:0] byte_position_next;
  logic [OFFSET_BITS-1:0] next_mark_next;
  phase_t                 walk_phase_next;
  logic [7:0]             previous_byte_next;
  logic                   first_block_seen_next;
  logic                   walk_finished_next;
  logic [LEN_W-1:0]       max_file_size;
  logic [MIN_W-1:0]       min_file_size;
  result_t                step_result;
  logic                   can_load;
  logic                   accept;

  assign byte_in.ready = can_load;
  assign accept        = byte_in.valid && can_load;

  gbsw_walker_regs #(.OFFSET_BITS(OFFSET_BITS)) u_regs (
    .clk                   (clk),
    .rst                   (rst),
    .advance               (accept),
    .cfg_write             (cfg_write),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .byte_position_next    (byte_position_next),
    .next_mark_next        (next_mark_next),
    .walk_phase_next       (walk_phase_next),
    .previous_byte_next    (previous_byte_next),
    .first_block_seen_next (first_block_seen_next),
    .walk_finished_next    (walk_finished_next),
    .byte_position         (byte_position),
    .next_mark             (next_mark),
    .walk_phase            (walk_phase),
    .previous_byte         (previous_byte),
    .first_block_seen      (first_block_seen),
    .walk_finished         (walk_finished),
    .max_file_size         (max_file_size),
    .min_file_size         (min_file_size)
  );

  gbsw_step #(.OFFSET_BITS(OFFSET_BITS)) u_step (
    .data_byte             (byte_in.data_byte),
    .first_byte            (byte_in.first_byte),
    .end_of_data           (byte_in.end_of_data),
    .byte_position         (byte_position),
    .next_mark             (next_mark),
    .walk_phase            (walk_phase),
    .previous_byte         (previous_byte),
    .first_block_seen      (first_block_seen),
    .walk_finished         (walk_finished),
    .max_file_size         (max_file_size),
    .min_file_size         (min_file_size),
    .byte_position_next    (byte_position_next),
    .next_mark_next        (next_mark_next),
    .walk_phase_next       (walk_phase_next),
    .previous_byte_next    (previous_byte_next),
    .first_block_seen_next (first_block_seen_next),
    .walk_finished_next    (walk_finished_next),
    .result                (step_result)
  );

  gbsw_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (byte_in.valid),
    .d          (step_result),
    .can_load   (can_load),
    .result_out (result_out)
  );

endmodule

@@ sim/gbsw_walk_check.sv @@
// Scoreboard of the GIF walker bench: predicts the result of every byte and checks it.
module gbsw_walk_check import gbsw_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 40
) (
  input  logic             clk,
  input  logic             rst,
  gbsw_byte_if             byte_mon,
  gbsw_result_if           result_mon,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int unsigned      outstanding,
  output int unsigned      mismatches,
  output int unsigned      walked_bytes,
  output int unsigned      checked,
  output int unsigned      valid_ends
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] OFFSET_MAX    = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - OFFSET_BITS);
  localparam logic [47:0] GIF_SIGNATURE = 48'h47_49_46_38_37_61;

  logic [LEN_W-1:0] size_cap;
  logic [MIN_W-1:0] size_floor;
  logic [63:0]      offset;
  logic [63:0]      mark;
  phase_t           phase;
  logic [7:0]       last_byte;
  logic             block_seen;
  logic             walk_done;
  result_t          expected_q[$];
  int unsigned      n_mismatch, n_walked, n_checked, n_valid;

  function automatic logic [63:0] palette_bytes(input logic [7:0] flags);
    return flags[7] ? (64'd3 << ({1'b0, flags[2:0]} + 4'd1)) : 64'd0;
  endfunction

  // Moves the next block offset and tells whether it has run into the size limit.
  function automatic logic move_mark(input logic [63:0] target);
    mark = target & OFFSET_MAX;
    return (target >= 64'(size_cap)) || (target > OFFSET_MAX);
  endfunction

  function automatic void restart_walk();
    offset     = '0;
    mark       = '0;
    phase      = PH_HEADER;
    last_byte  = '0;
    block_seen = 1'b0;
    walk_done  = 1'b0;
  endfunction

  function automatic result_t walk_byte(input logic [7:0] b, input logic first,
                                        input logic eod);
    result_t     res;
    logic        stop;
    logic        limit_hit;
    logic [63:0] pos;
    res.status      = ST_RUN;
    res.file_length = '0;
    stop            = 1'b0;
    limit_hit       = 1'b0;
    if (first) restart_walk();
    if (walk_done) return res;
    pos = offset;

    if (phase == PH_HEADER) begin
      if (pos < HDR_BYTES) begin
        if (b != 8'(GIF_SIGNATURE >> (8 * (5 - pos))) && !(pos == 4 && b == SIG_VER_NINE)) begin
          res.status = ST_FORMAT;
          stop       = 1'b1;
        end
      end else if (pos == SCREEN_FLAGS) begin
        phase     = PH_BLOCK;
        limit_hit = move_mark(64'(SCREEN_END) + palette_bytes(b));
      end
    end else if (pos == mark) begin
      case (phase)
        PH_BLOCK: begin
          if (b == BLK_EXTENSION) begin
            block_seen = 1'b1;
            phase      = PH_SUB;
            limit_hit  = move_mark(pos + EXT_SKIP);
          end else if (b == BLK_IMAGE) begin
            block_seen = 1'b1;
            phase      = PH_DESC;
            limit_hit  = move_mark(pos + IMAGE_SKIP);
          end else if (b == BLK_TRAILER && block_seen) begin
            stop = 1'b1;
            if (last_byte != BYTE_ZERO) begin
              res.status = ST_FORMAT;
            end else if (pos + 1 < 64'(size_floor)) begin
              res.status = ST_SHORT;
            end else begin
              res.status      = ST_VALID;
              res.file_length = LEN_W'(pos + 1);
            end
          end else begin
            res.status = ST_FORMAT;
            stop       = 1'b1;
          end
        end
        PH_DESC: begin
          phase     = PH_SUB;
          limit_hit = move_mark(pos + DESC_SKIP + palette_bytes(b));
        end
        default: begin
          // A zero-length sub-block closes the chain and the next block byte follows it.
          limit_hit = move_mark(pos + SUB_SKIP + b);
          if (b == BYTE_ZERO) phase = PH_BLOCK;
        end
      endcase
    end

    if (limit_hit) begin
      res.status = ST_LIMIT;
      stop       = 1'b1;
    end
    last_byte = b;
    offset    = (pos + 1) & OFFSET_MAX;
    if (!stop && eod) begin
      res.status = ST_TRUNC;
      stop       = 1'b1;
    end
    walk_done = stop;
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    n_mismatch++;
    if (n_mismatch <= 10) $display("[%0t] result mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      size_cap   = MAX_SIZE_RESET;
      size_floor = MIN_SIZE_RESET;
      restart_walk();
      expected_q.delete();
      n_mismatch = 0;
      n_walked   = 0;
      n_checked  = 0;
      n_valid    = 0;
    end else begin
      // A result leaves the block only from the result register, after its byte is accepted, so its prediction
      // is already queued here.
      if (result_mon.valid && result_mon.ready) begin
        n_checked++;
        if (expected_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected transaction with status %0d length %0d",
                                  result_mon.status, result_mon.file_length));
        end else begin
          want = expected_q.pop_front();
          if (result_mon.status !== want.status ||
              result_mon.file_length !== want.file_length)
            flag_mismatch($sformatf("expected status %0d length %0d, got status %0d length %0d",
                                    want.status, want.file_length,
                                    result_mon.status, result_mon.file_length));
        end
      end
      if (byte_mon.valid && byte_mon.ready) begin
        if (byte_mon.first_byte || !walk_done) n_walked++;
        want = walk_byte(byte_mon.data_byte, byte_mon.first_byte, byte_mon.end_of_data);
        if (want.status == ST_VALID) n_valid++;
        expected_q.push_back(want);
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_MAX_SIZE: size_cap   = cfg_data[LEN_W-1:0];
          REG_MIN_SIZE: size_floor = cfg_data[MIN_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding  <= expected_q.size();
    mismatches   <= n_mismatch;
    walked_bytes <= n_walked;
    checked      <= n_checked;
    valid_ends   <= n_valid;
  end

endmodule

@@ sim/testbench.sv @@
// Top of the GIF walker bench: clock, reset, GIF byte streams, register phases and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gbsw_pkg::*;

  localparam int unsigned WALK_TARGET = 1200;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_write;
  reg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int unsigned      outstanding, mismatches, walked_bytes, checked, valid_ends;
  int unsigned      idle_mode  = 0;
  int unsigned      stall_left = 0;
  int unsigned      cycles     = 0;
  int unsigned      files_sent = 0;
  int unsigned      bytes_sent = 0;
  logic [7:0]       gif_bytes[$];

  gbsw_byte_if   byte_ch();
  gbsw_result_if result_ch();

  gif_block_structure_walker DUT (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_ch),
    .result_out (result_ch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  gbsw_walk_check walk_check (
    .clk          (clk),
    .rst          (rst),
    .byte_mon     (byte_ch),
    .result_mon   (result_ch),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .mismatches   (mismatches),
    .walked_bytes (walked_bytes),
    .checked      (checked),
    .valid_ends   (valid_ends)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (idle_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly small color tables keep the files short; the largest ones come rarely.
  function automatic logic [7:0] draw_flags();
    logic [7:0] flags;
    flags      = 8'($urandom);
    flags[2:0] = 3'($urandom_range(0, 2));
    if ($urandom_range(0, 24) == 0) flags[2:0] = 3'($urandom_range(3, 7));
    return flags;
  endfunction

  function automatic int unsigned palette_len(input logic [7:0] flags);
    return flags[7] ? (3 << (flags[2:0] + 1)) : 0;
  endfunction

  // The result side stalls on its own schedule.
  always @(posedge clk) begin
    if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    if (stall_left != 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
    $display("Regression FAIL");
    $finish;
  end

  task automatic put_random(input int unsigned n);
    repeat (n) gif_bytes.push_back(8'($urandom));
  endtask

  task automatic put_signature(input logic [47:0] sig);
    for (int i = 0; i < 6; i++) gif_bytes.push_back(sig[47 - 8*i -: 8]);
  endtask

  task automatic put_header(input logic nine, input logic [7:0] flags);
    put_signature(nine ? "GIF89a" : "GIF87a");
    put_random(4);
    gif_bytes.push_back(flags);
    put_random(2 + palette_len(flags));
  endtask

  task automatic put_chain(input int unsigned blocks, input int unsigned max_len);
    int unsigned len;
    repeat (blocks) begin
      len = $urandom_range(1, max_len);
      gif_bytes.push_back(8'(len));
      put_random(len);
    end
    gif_bytes.push_back(BYTE_ZERO);
  endtask

  task automatic put_block(input logic image, input logic [7:0] flags,
                           input int unsigned blocks, input int unsigned max_len);
    if (image) begin
      gif_bytes.push_back(BLK_IMAGE);
      put_random(8);
      gif_bytes.push_back(flags);
      put_random(1 + palette_len(flags));
    end else begin
      gif_bytes.push_back(BLK_EXTENSION);
      put_random(1);
    end
    put_chain(blocks, max_len);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= b;
    byte_ch.first_byte  <= first;
    byte_ch.end_of_data <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_file(input logic eod_last);
    idle_mode <= $urandom_range(0, 3);
    foreach (gif_bytes[i])
      send_byte(gif_bytes[i], i == 0, eod_last && i == gif_bytes.size() - 1);
    gif_bytes.delete();
    files_sent++;
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_limits(input logic [LEN_W-1:0] max_size, input logic [MIN_W-1:0] min_size);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= REG_MAX_SIZE;
    cfg_data  <= CFG_W'(max_size);
    @(posedge clk);
    cfg_index <= REG_MIN_SIZE;
    cfg_data  <= CFG_W'(min_size);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly well-formed files with random content; the rest are cut, damaged or noise.
  task automatic random_file();
    int unsigned kind;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    if (kind >= 95) begin
      if (kind >= 97) put_header(1'($urandom), draw_flags());
      put_random($urandom_range(1, 20));
      send_file(1'($urandom));
    end else begin
      put_header(1'($urandom), draw_flags());
      repeat ($urandom_range(1, 4))
        put_block(1'($urandom), draw_flags(), $urandom_range(0, 3),
                  ($urandom_range(0, 9) == 0) ? 255 : 12);
      gif_bytes.push_back(BLK_TRAILER);
      if (kind < 55) begin
        // Bytes after the trailer must come back as plain in-progress answers.
        if ($urandom_range(0, 3) == 0) put_random($urandom_range(1, 4));
        send_file(1'($urandom));
      end else if (kind < 70) begin
        // Without end of data the next file's first byte cuts the walk short.
        cut = $urandom_range(1, gif_bytes.size() - 1);
        while (gif_bytes.size() > cut) void'(gif_bytes.pop_back());
        send_file(kind < 64);
      end else begin
        gif_bytes[$urandom_range(0, gif_bytes.size() - 1)] = 8'($urandom);
        send_file(1'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned quota;
    rst                 <= 1'b1;
    cfg_write           <= 1'b0;
    cfg_index           <= REG_MAX_SIZE;
    cfg_data            <= '0;
    byte_ch.valid       <= 1'b0;
    byte_ch.data_byte   <= '0;
    byte_ch.first_byte  <= 1'b0;
    byte_ch.end_of_data <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed files under the reset limits: a short one, then a valid one with both tables.
    put_header(1'b0, 8'h00);
    put_block(1'b0, 8'h00, 0, 1);
    gif_bytes.push_back(BLK_TRAILER);
    send_file(1'b0);
    put_header(1'b1, 8'h81);
    put_block(1'b1, 8'h80, 1, 12);
    gif_bytes.push_back(BLK_TRAILER);
    send_file(1'b1);
    put_signature("XIF89a");
    send_file(1'b0);
    put_signature("GIF88a");
    send_file(1'b0);
    // A trailer cannot be the first block.
    put_header(1'b1, 8'h00);
    gif_bytes.push_back(BLK_TRAILER);
    send_file(1'b0);
    put_header(1'b0, 8'h00);
    put_block(1'b0, 8'h00, 1, 4);
    gif_bytes.push_back(8'hff);
    put_random(2);
    send_file(1'b0);
    put_header(1'b1, 8'h00);
    send_file(1'b1);
    put_header(1'b0, 8'h00);
    put_block(1'b1, 8'h00, 2, 8);
    send_file(1'b0);

    // An image descriptor at offset 13 needs offset 22, beyond a 20-byte limit.
    set_limits(20, 0);
    put_header(1'b0, 8'h00);
    put_block(1'b1, 8'h00, 1, 12);
    send_file(1'b0);
    set_limits(1, 0);
    put_header(1'b1, 8'h00);
    put_random(3);
    send_file(1'b0);
    set_limits(MAX_SIZE_RESET, 16'hffff);
    put_header(1'b1, 8'h00);
    put_block(1'b0, 8'h00, 0, 1);
    gif_bytes.push_back(BLK_TRAILER);
    send_file(1'b0);
    set_limits(MAX_SIZE_RESET, 0);
    put_header(1'b0, 8'h00);
    put_block(1'b0, 8'h00, 0, 1);
    gif_bytes.push_back(BLK_TRAILER);
    send_file(1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_limits(MAX_SIZE_RESET, MIN_SIZE_RESET);
        1: set_limits(LEN_W'($urandom_range(40, 300)), MIN_W'($urandom_range(0, 80)));
        2: set_limits(1, 0);
        3: set_limits(MAX_SIZE_RESET, 16'hffff);
        4: set_limits(LEN_W'($urandom_range(60, 2000)), 0);
        default: set_limits({$urandom, 8'($urandom)}, MIN_W'($urandom_range(0, 120)));
      endcase
      quota = bytes_sent + ((ph == 2 || ph == 3) ? 70 : (WALK_TARGET - 140) / 4);
      while (bytes_sent < quota) random_file();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Sent %0d bytes in %0d candidate files over ten limit settings; %0d were walked.",
             bytes_sent, files_sent, walked_bytes);
    $display("Checked %0d results, %0d of them valid file ends, %0d mismatches.",
             checked, valid_ends, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/gbsw_pkg.sv
design/gbsw_byte_if.sv
design/gbsw_result_if.sv
design/gbsw_step.sv
design/gbsw_out_stage.sv
design/gbsw_walker_regs.sv
design/gif_block_structure_walker.sv
sim/gbsw_walk_check.sv
sim/testbench.sv
